FILE: sv/tbmnt_pkg.sv
// ----------------------------------------------------------------------------
// tbmnt_pkg: shared types and constants for the tick barrier
// Field widths, configuration defaults and the default store depth.
// ----------------------------------------------------------------------------
`default_nettype none

package tbmnt_pkg;

   localparam int TICK_WIDTH         = 64;
   localparam int PORT_WIDTH         = 16;
   localparam int CLIENT_COUNT_WIDTH = 5;
   localparam int MAX_CLIENTS_DEFAULT = 16;

   typedef logic [TICK_WIDTH-1:0]         tick_type;
   typedef logic [PORT_WIDTH-1:0]         port_type;
   typedef logic [CLIENT_COUNT_WIDTH-1:0] client_count_type;

   localparam client_count_type CLIENT_COUNT_RESET = client_count_type'(1);

endpackage : tbmnt_pkg

`default_nettype wire

FILE: sv/tick_barrier_min_next_time.sv
// ----------------------------------------------------------------------------
// tick_barrier_min_next_time: simulation time barrier
// Collects client acknowledgements for the current tick, tracks the earliest
// later tick requested and advances the clock once enough distinct clients
// have acknowledged.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req_    | in        | valid / stall      | client_port, client_tick,
//           |           |                    | requested_tick
//   rsp_    | out       | valid / stall      | ack_accepted, clock_advanced,
//           |           |                    | clock_now
//   csr_    | in        | valid / ready      | client_count
//
// One transaction per cycle sustained while rsp_stall is low. The path has an
// input register, then the port compare against the store, the min compare and
// the count update combinationally into the result register. Reset is synchronous
// and clears the clock, the round state and client_count to one. A stalled
// result holds in the result register while the input register still takes
// one more transaction; req_stall rises only when both are occupied.
//
`default_nettype none

module tick_barrier_min_next_time
   import tbmnt_pkg::*;
#(
   parameter int MAX_CLIENTS = MAX_CLIENTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [PORT_WIDTH-1:0]         req_client_port,
   input  wire logic [TICK_WIDTH-1:0]         req_client_tick,
   input  wire logic [TICK_WIDTH-1:0]         req_requested_tick,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ack_accepted,
   output logic                               rsp_clock_advanced,
   output logic [TICK_WIDTH-1:0]              rsp_clock_now,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CLIENT_COUNT_WIDTH-1:0] csr_client_count
);

   // count holds 0..MAX_CLIENTS, index addresses 0..MAX_CLIENTS-1
   localparam int CW = $clog2(MAX_CLIENTS + 1);
   localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int TW = (CW > CLIENT_COUNT_WIDTH) ? CW : CLIENT_COUNT_WIDTH;

   typedef logic [CW-1:0] count_type;
   typedef logic [TW-1:0] target_type;

   // configuration register
   client_count_type client_count_ff;

   // barrier state
   tick_type  current_tick_ff,  current_tick_in;
   tick_type  earliest_tick_ff, earliest_tick_in;
   count_type acked_count_ff,   acked_count_in;
   port_type  acked_ports_ff [MAX_CLIENTS];

   // input register
   logic     s1_valid_ff;
   port_type s1_port_ff;
   tick_type s1_ctick_ff;
   tick_type s1_want_ff;

   // result register
   logic     rsp_valid_ff;
   logic     rsp_accepted_ff,  rsp_accepted_in;
   logic     rsp_advanced_ff,  rsp_advanced_in;
   tick_type rsp_clock_ff;

   logic       out_ready;
   logic       s1_fire;
   logic       tick_match;
   logic       port_hit;
   logic       store_port;
   target_type target;
   target_type count_ext;
   target_type count_mid;

   // handshakes
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign csr_ready = 1'b1;

   // store configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         client_count_ff <= CLIENT_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         client_count_ff <= csr_client_count;
      end
   end

   // capture accepted request transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_port_ff  <= req_client_port;
         s1_ctick_ff <= req_client_tick;
         s1_want_ff  <= req_requested_tick;
      end
   end

   // search the port store over the entries filled this round
   always_comb begin
      port_hit = 1'b0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
         if ((count_type'(i) < acked_count_ff) && (acked_ports_ff[i] == s1_port_ff)) begin
            port_hit = 1'b1;
         end
      end
   end

   // saturate the configured target at the store depth
   always_comb begin
      if (target_type'(client_count_ff) > target_type'(MAX_CLIENTS)) begin
         target = target_type'(MAX_CLIENTS);
      end else begin
         target = target_type'(client_count_ff);
      end
   end

   assign tick_match = (s1_ctick_ff == current_tick_ff);
   assign count_ext  = target_type'(acked_count_ff);

   // update the round: lower the minimum, record the port, close the round
   always_comb begin
      current_tick_in  = current_tick_ff;
      earliest_tick_in = earliest_tick_ff;
      acked_count_in   = acked_count_ff;
      store_port       = 1'b0;
      rsp_accepted_in  = 1'b0;
      rsp_advanced_in  = 1'b0;
      count_mid        = count_ext;
      if (tick_match) begin
         rsp_accepted_in = 1'b1;
         if (count_ext != target) begin
            if (s1_want_ff > current_tick_ff) begin
               if ((earliest_tick_ff == current_tick_ff) || (s1_want_ff < earliest_tick_ff)) begin
                  earliest_tick_in = s1_want_ff;
               end
            end
            if (!port_hit && (acked_count_ff < count_type'(MAX_CLIENTS))) begin
               store_port = 1'b1;
               count_mid  = count_ext + target_type'(1);
            end
         end
         if (count_mid == target) begin
            acked_count_in  = '0;
            current_tick_in = earliest_tick_in;
            rsp_advanced_in = 1'b1;
         end else begin
            acked_count_in  = count_type'(count_mid);
         end
      end
   end

   // advance barrier state
   always_ff @(posedge clock) begin
      if (reset) begin
         current_tick_ff  <= '0;
         earliest_tick_ff <= '0;
         acked_count_ff   <= '0;
      end else if (s1_fire) begin
         current_tick_ff  <= current_tick_in;
         earliest_tick_ff <= earliest_tick_in;
         acked_count_ff   <= acked_count_in;
      end
   end

   // write the port store
   always_ff @(posedge clock) begin
      if (s1_fire && store_port) begin
         acked_ports_ff[acked_count_ff[IW-1:0]] <= s1_port_ff;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_advanced_ff <= rsp_advanced_in;
         rsp_clock_ff    <= current_tick_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ack_accepted   = rsp_accepted_ff;
   assign rsp_clock_advanced = rsp_advanced_ff;
   assign rsp_clock_now      = rsp_clock_ff;

endmodule : tick_barrier_min_next_time

`default_nettype wire
